FILE: sv/bmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmsd_pkg;

  localparam int SampleW    = 16;
  localparam int MaxSamples = 65536;
  localparam int CountW     = $clog2(MaxSamples + 1);
  localparam int SumW       = SampleW + CountW;
  localparam int SqW        = 2 * SampleW - 2 + CountW;
  localparam int VarW       = SqW + 1;
  localparam int RootW      = VarW / 2;
  localparam int RemW       = CountW;
  localparam int RootRemW   = RootW + 2;
  localparam int StepW      = $clog2(SqW);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int InDataW    = 16;
  localparam int OutDataW   = 160;
  localparam int OutUserW   = 2;

  typedef struct packed {
    logic [CountW-1:0]         count;
    logic                      drop;
    logic signed [SampleW-1:0] min_val;
    logic signed [SampleW-1:0] max_val;
    logic signed [SumW-1:0]    sum;
    logic [SqW-1:0]            sumsq;
  } stats_t;

  typedef struct packed {
    logic signed [SampleW-1:0] mean;
    logic [SampleW-1:0]        std_dev;
    logic signed [SampleW-1:0] minimum;
    logic signed [SampleW-1:0] maximum;
    logic signed [31:0]        total;
    logic [SqW-1:0]            total_squares;
    logic [CountW-1:0]         n_valid;
    logic                      empty_res;
    logic                      overflowed;
  } result_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_MEAN = 6'b000100,
    S_VAR  = 6'b001000,
    S_ROOT = 6'b010000,
    S_DONE = 6'b100000
  } back_state_e;

endpackage

`default_nettype wire

FILE: sv/bmsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [bmsd_pkg::InDataW-1:0] s_axis_tdata,  // sample
  input  wire logic [0:0]                   s_axis_tuser,  // invalid
  input  wire logic                         s_axis_tlast,
  input  wire logic                         full_i,
  output logic                              push_o,
  output bmsd_pkg::stats_t                  snap_o
);

  bmsd_pkg::stats_t stat_q, stat_d, stat_n;
  logic accept;
  logic signed [bmsd_pkg::SampleW-1:0]   smp;
  logic signed [2*bmsd_pkg::SampleW-1:0] prod;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign smp           = $signed(s_axis_tdata[bmsd_pkg::SampleW-1:0]);
  assign prod          = smp * smp;

  always_comb begin
    stat_n = stat_q;
    if (accept && !s_axis_tuser[0]) begin
      if (stat_q.count >= bmsd_pkg::CountW'(bmsd_pkg::MaxSamples)) begin
        stat_n.drop = 1'b1;
      end else begin
        if (stat_q.count == '0) begin
          stat_n.min_val = smp;
          stat_n.max_val = smp;
        end else begin
          if (smp < $signed(stat_q.min_val)) stat_n.min_val = smp;
          if (smp > $signed(stat_q.max_val)) stat_n.max_val = smp;
        end
        stat_n.sum   = stat_q.sum
                     + {{(bmsd_pkg::SumW-bmsd_pkg::SampleW){smp[bmsd_pkg::SampleW-1]}}, smp};
        stat_n.sumsq = stat_q.sumsq
                     + {{(bmsd_pkg::SqW-2*bmsd_pkg::SampleW){1'b0}}, prod};
        stat_n.count = stat_q.count + bmsd_pkg::CountW'(1);
      end
    end
  end

  always_comb begin
    stat_d = stat_q;
    if (accept) begin
      stat_d = s_axis_tlast ? '0 : stat_n;
    end
  end

  assign push_o = accept && s_axis_tlast;
  assign snap_o = stat_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  a_drop_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_q.drop |-> stat_q.count == bmsd_pkg::CountW'(bmsd_pkg::MaxSamples))
    else $error("drop set below capacity");

endmodule

`default_nettype wire

FILE: sv/bmsd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bmsd_pkg::stats_t data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output bmsd_pkg::stats_t      data_o
);

  bmsd_pkg::stats_t            mem_q [bmsd_pkg::QueueDepth];
  logic [bmsd_pkg::QPtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [bmsd_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = cnt_q == bmsd_pkg::QCntW'(bmsd_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = wptr_q + bmsd_pkg::QPtrW'(1);
    if (do_pop)  rptr_d = rptr_q + bmsd_pkg::QPtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + bmsd_pkg::QCntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - bmsd_pkg::QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("batch word pushed into full queue");

endmodule

`default_nettype wire

FILE: sv/bmsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire bmsd_pkg::stats_t snap_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output bmsd_pkg::result_t     res_o
);

  bmsd_pkg::back_state_e state_q, state_d;
  bmsd_pkg::stats_t      snap_q, snap_d;
  logic [bmsd_pkg::StepW-1:0]    step_q, step_d;
  logic [bmsd_pkg::SqW-1:0]      d1_q, d1_d, d2_q, d2_d;
  logic [bmsd_pkg::RemW-1:0]     r1_q, r1_d, r2_q, r2_d;
  logic signed [bmsd_pkg::SampleW-1:0] mean_q, mean_d;
  logic [bmsd_pkg::VarW-1:0]     x_q, x_d;
  logic [bmsd_pkg::RootW-1:0]    root_q, root_d;
  logic [bmsd_pkg::RootRemW-1:0] rr_q, rr_d;
  logic                          out_valid_q, out_valid_d;
  bmsd_pkg::result_t             out_q, out_d;

  logic [bmsd_pkg::SumW-1:0]     sum_mag;
  logic [bmsd_pkg::RemW:0]       t1, t2, cnt_ext;
  logic [bmsd_pkg::SampleW:0]    qmag;
  logic [2*bmsd_pkg::SampleW-1:0] msq;
  logic [bmsd_pkg::VarW-1:0]     diff;
  logic [bmsd_pkg::RootRemW+1:0] rt, trial;
  logic                          is_empty, load_out;

  assign sum_mag = snap_i.sum[bmsd_pkg::SumW-1] ? -snap_i.sum : snap_i.sum;
  assign cnt_ext = {1'b0, snap_q.count};
  assign t1      = {r1_q, d1_q[bmsd_pkg::SqW-1]};
  assign t2      = {r2_q, d2_q[bmsd_pkg::SqW-1]};
  assign qmag    = d1_q[bmsd_pkg::SampleW:0] + {{bmsd_pkg::SampleW{1'b0}}, (r1_q != '0)};
  assign msq     = $unsigned(32'(mean_q) * 32'(mean_q));
  assign diff    = {1'b0, d2_q} - {{(bmsd_pkg::VarW-2*bmsd_pkg::SampleW){1'b0}}, msq};
  assign rt      = {rr_q, x_q[bmsd_pkg::VarW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign is_empty = snap_q.count == '0;
  assign load_out = (state_q == bmsd_pkg::S_DONE) && (!out_valid_q || res_ready_i);

  assign pop_o       = (state_q == bmsd_pkg::S_IDLE) && valid_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d = state_q;
    snap_d  = snap_q;
    step_d  = step_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    mean_d  = mean_q;
    x_d     = x_q;
    root_d  = root_q;
    rr_d    = rr_q;
    unique case (state_q)
      bmsd_pkg::S_IDLE: begin
        if (valid_i) begin
          snap_d = snap_i;
          d1_d   = {{(bmsd_pkg::SqW-bmsd_pkg::SumW){1'b0}}, sum_mag};
          d2_d   = snap_i.sumsq;
          r1_d   = '0;
          r2_d   = '0;
          step_d = '0;
          mean_d = '0;
          root_d = '0;
          state_d = (snap_i.count == '0) ? bmsd_pkg::S_DONE : bmsd_pkg::S_DIV;
        end
      end
      bmsd_pkg::S_DIV: begin
        if (t1 >= cnt_ext) begin
          r1_d = bmsd_pkg::RemW'(t1 - cnt_ext);
          d1_d = {d1_q[bmsd_pkg::SqW-2:0], 1'b1};
        end else begin
          r1_d = t1[bmsd_pkg::RemW-1:0];
          d1_d = {d1_q[bmsd_pkg::SqW-2:0], 1'b0};
        end
        if (t2 >= cnt_ext) begin
          r2_d = bmsd_pkg::RemW'(t2 - cnt_ext);
          d2_d = {d2_q[bmsd_pkg::SqW-2:0], 1'b1};
        end else begin
          r2_d = t2[bmsd_pkg::RemW-1:0];
          d2_d = {d2_q[bmsd_pkg::SqW-2:0], 1'b0};
        end
        if (step_q == bmsd_pkg::StepW'(bmsd_pkg::SqW - 1)) begin
          step_d  = '0;
          state_d = bmsd_pkg::S_MEAN;
        end else begin
          step_d = step_q + bmsd_pkg::StepW'(1);
        end
      end
      bmsd_pkg::S_MEAN: begin
        if (snap_q.sum[bmsd_pkg::SumW-1]) begin
          mean_d = $signed(bmsd_pkg::SampleW'(-qmag));
        end else begin
          mean_d = $signed(d1_q[bmsd_pkg::SampleW-1:0]);
        end
        state_d = bmsd_pkg::S_VAR;
      end
      bmsd_pkg::S_VAR: begin
        x_d     = diff[bmsd_pkg::VarW-1] ? '0 : diff;
        rr_d    = '0;
        root_d  = '0;
        step_d  = '0;
        state_d = bmsd_pkg::S_ROOT;
      end
      bmsd_pkg::S_ROOT: begin
        x_d = {x_q[bmsd_pkg::VarW-3:0], 2'b00};
        if (rt >= trial) begin
          rr_d   = bmsd_pkg::RootRemW'(rt - trial);
          root_d = {root_q[bmsd_pkg::RootW-2:0], 1'b1};
        end else begin
          rr_d   = rt[bmsd_pkg::RootRemW-1:0];
          root_d = {root_q[bmsd_pkg::RootW-2:0], 1'b0};
        end
        if (step_q == bmsd_pkg::StepW'(bmsd_pkg::RootW - 1)) begin
          state_d = bmsd_pkg::S_DONE;
        end else begin
          step_d = step_q + bmsd_pkg::StepW'(1);
        end
      end
      bmsd_pkg::S_DONE: begin
        if (load_out) state_d = bmsd_pkg::S_IDLE;
      end
      default: state_d = bmsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (load_out) begin
      out_valid_d         = 1'b1;
      out_d.mean          = is_empty ? '0 : mean_q;
      out_d.std_dev       = is_empty ? '0 : root_q[bmsd_pkg::SampleW-1:0];
      out_d.minimum       = is_empty ? '0 : snap_q.min_val;
      out_d.maximum       = is_empty ? '0 : snap_q.max_val;
      out_d.total         = $signed(snap_q.sum[31:0]);
      out_d.total_squares = snap_q.sumsq;
      out_d.n_valid       = snap_q.count;
      out_d.empty_res     = is_empty;
      out_d.overflowed    = snap_q.drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmsd_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    r1_q   <= r1_d;
    r2_q   <= r2_d;
    mean_q <= mean_d;
    x_q    <= x_d;
    root_q <= root_d;
    rr_q   <= rr_d;
    out_q  <= out_d;
  end

  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.empty_res) |->
      ($signed(out_q.mean) >= $signed(out_q.minimum)) &&
      ($signed(out_q.mean) <= $signed(out_q.maximum)))
    else $error("mean outside min..max");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.empty_res) |->
      (out_q.n_valid == '0) && (out_q.std_dev == '0) && (out_q.mean == '0))
    else $error("empty batch with non-zero statistics");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmsd_pkg::S_DIV) && (state_d != bmsd_pkg::S_DIV) |->
      step_q == bmsd_pkg::StepW'(bmsd_pkg::SqW - 1))
    else $error("divider left early");

endmodule

`default_nettype wire

FILE: sv/batch_mean_stddev_min_max_core.sv
// Input: one sample word per cycle; tready drops only while two finished batches wait.
// Result path: each batch runs a 47-step divider and a 24-step square root before its
// result word; a batch with no valid sample skips both.
// Results: one batch at a time through the shared divide/root sequencer; the next batch waits in the queue.
// Reset: rst_ni asynchronous, active low; clears accumulators, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module batch_mean_stddev_min_max_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [bmsd_pkg::InDataW-1:0]   s_axis_tdata,  // sample
  input  wire logic [0:0]                     s_axis_tuser,  // invalid
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // mean, std_dev, minimum, maximum, total, total_squares, n_valid
  output logic [bmsd_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [bmsd_pkg::OutUserW-1:0]       m_axis_tuser   // empty_res, overflowed
);

  bmsd_pkg::stats_t  push_data, pop_data;
  bmsd_pkg::result_t res;
  logic push, full, q_valid, pop;

  bmsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .snap_o        (push_data)
  );

  bmsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_data)
  );

  bmsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .snap_i      (pop_data),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.n_valid, res.total_squares, res.total, res.maximum,
                         res.minimum, res.std_dev, res.mean};
  assign m_axis_tuser = {res.overflowed, res.empty_res};

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int RxHoldCycles  = 400;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 100;
  localparam int RandomWords   = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bmsd_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]                    s_axis_tuser = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [bmsd_pkg::OutDataW-1:0] m_axis_tdata;
  logic [bmsd_pkg::OutUserW-1:0] m_axis_tuser;

  batch_mean_stddev_min_max_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // batch accumulators mirrored from accepted words
  longint acc_sum = 0;
  longint acc_sq = 0;
  longint acc_min = 0;
  longint acc_max = 0;
  longint acc_count = 0;
  logic   acc_drop = 1'b0;

  bmsd_pkg::result_t stats_due[$];
  int      error_count = 0;
  int      stall_cycles = 0;

  int   tx_gap_max = 0;
  int   burst_left = 0;
  logic rx_stall_on = 1'b0;
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;
  logic [7:0] rx_pat = 8'hff;
  int   rx_pat_age = 0;

  function automatic longint root_floor(input longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      longint t;
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  task automatic track_sample(input logic [15:0] smp, input logic bad, input logic fin);
    longint  s;
    longint  quot;
    longint  spread;
    bmsd_pkg::result_t r;
    s = longint'($signed(smp));
    if (!bad) begin
      if (acc_count >= bmsd_pkg::MaxSamples) begin
        acc_drop = 1'b1;
      end else begin
        if (acc_count == 0 || s < acc_min) acc_min = s;
        if (acc_count == 0 || s > acc_max) acc_max = s;
        acc_sum += s;
        acc_sq += s * s;
        acc_count++;
      end
    end
    if (fin) begin
      r = '0;
      if (acc_count > 0) begin
        quot = acc_sum / acc_count;
        if (acc_sum < 0 && quot * acc_count != acc_sum) quot--;
        spread = acc_sq / acc_count - quot * quot;
        if (spread < 0) spread = 0;
        r.mean    = quot[15:0];
        r.std_dev = 16'(root_floor(spread));
        r.minimum = acc_min[15:0];
        r.maximum = acc_max[15:0];
      end
      r.total         = acc_sum[31:0];
      r.total_squares = acc_sq[bmsd_pkg::SqW-1:0];
      r.n_valid       = acc_count[bmsd_pkg::CountW-1:0];
      r.empty_res     = (acc_count == 0);
      r.overflowed    = acc_drop;
      stats_due.push_back(r);
      acc_sum = 0;
      acc_sq = 0;
      acc_min = 0;
      acc_max = 0;
      acc_count = 0;
      acc_drop = 1'b0;
    end
  endtask

  task automatic cmp_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic check_stats();
    bmsd_pkg::result_t want;
    if (stats_due.size() == 0) begin
      $display("%0t ns: unexpected result word, expected none, actual %h / %b",
               $time, m_axis_tdata, m_axis_tuser);
      error_count++;
    end else begin
      want = stats_due.pop_front();
      cmp_field("mean", $signed(want.mean), $signed(m_axis_tdata[15:0]));
      cmp_field("std_dev", want.std_dev, m_axis_tdata[31:16]);
      cmp_field("minimum", $signed(want.minimum), $signed(m_axis_tdata[47:32]));
      cmp_field("maximum", $signed(want.maximum), $signed(m_axis_tdata[63:48]));
      cmp_field("total", $signed(want.total), $signed(m_axis_tdata[95:64]));
      cmp_field("total_squares", want.total_squares, m_axis_tdata[142:96]);
      cmp_field("n_valid", want.n_valid, m_axis_tdata[159:143]);
      cmp_field("empty_res", want.empty_res, m_axis_tuser[0]);
      cmp_field("overflowed", want.overflowed, m_axis_tuser[1]);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      track_sample(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_stats();
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("batch_mean_stddev_min_max_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: long hold on request, else a rotating stall pattern
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RxHoldCycles;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_pat_age == 0) begin
        rx_pat = rx_stall_on ? (8'($urandom) | 8'h11) : 8'hff;
        rx_pat_age = $urandom_range(8, 40);
      end
      rx_pat_age--;
      rx_pat = {rx_pat[6:0], rx_pat[7]};
      m_axis_tready <= rx_pat[0];
    end
  end

  task automatic send_word(input logic [15:0] smp, input logic bad, input logic fin);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= bad;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic tx_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int len, input int bad_pct, input logic last_bad);
    logic bad;
    for (int i = 0; i < len; i++) begin
      bad = ($urandom_range(0, 99) < bad_pct);
      if (i == len - 1) bad = last_bad;
      send_word(pick_sample(), bad, i == len - 1);
    end
  endtask

  task automatic test_directed();
    tx_gap_max = 0;
    rx_stall_on = 1'b0;
    send_word(16'h7fff, 1'b0, 1'b1);
    send_word(16'h8000, 1'b0, 1'b1);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h7fff, 1'b0, 1'b1);
    // empty batch
    send_word(16'h1234, 1'b1, 1'b1);
    // invalid first word, then last mark on an invalid word
    send_word(16'hffff, 1'b1, 1'b0);
    send_word(16'h5555, 1'b0, 1'b0);
    send_word(16'haaaa, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b1);
    // mean floors to -1, variance goes negative and clamps
    send_word(16'hffff, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);
    send_word(16'hfffb, 1'b0, 1'b0);
    send_word(16'h0002, 1'b0, 1'b1);
    send_word(16'h0100, 1'b0, 1'b0);
    send_word(16'h0300, 1'b0, 1'b0);
    send_word(16'hfe00, 1'b0, 1'b1);
    tx_idle();
  endtask

  task automatic test_backpressure();
    tx_gap_max = 0;
    rx_stall_on = 1'b0;
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    for (int b = 0; b < 16; b++) send_batch($urandom_range(1, 3), 10, 1'b0);
    tx_idle();
  endtask

  task automatic test_random();
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < RandomWords) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 3);
        tx_gap_max = pick[0] ? $urandom_range(1, 8) : 0;
        rx_stall_on = pick[1];
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(1, 4);
      send_batch(len, (pick >= 95) ? 100 : 15, (pick >= 95) || ($urandom_range(0, 9) == 0));
      sent += len;
    end
    tx_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("batch_mean_stddev_min_max_core regression: pass");
    end else begin
      $display("batch_mean_stddev_min_max_core regression: fail");
    end
    $finish;
  end

endmodule
